[sv/pcrt_pkg.sv]
// ----------------------------------------------------------------------------
// Pending chunk request table: shared types
// Item structures, table entry layout, status codes and controller states.
// ----------------------------------------------------------------------------
package pcrt_pkg;

    localparam int CLOCK_W = 31;

    typedef enum logic [1:0] {
        ST_OK         = 2'd0,
        ST_KEYS_FULL  = 2'd1,
        ST_QUEUE_FULL = 2'd2
    } status_t;

    typedef enum logic {
        REQ_ADD   = 1'b0,
        REQ_REPLY = 1'b1
    } req_kind_t;

    typedef struct packed {
        logic               req_type;
        logic [7:0]         model;
        logic [15:0]        chunk;
        logic [CLOCK_W-1:0] clock_req;
        logic [7:0]         thread;
    } req_t;

    typedef struct packed {
        logic               send_needed;
        logic               thread_valid;
        logic [7:0]         released_thread;
        logic               resend_valid;
        logic [CLOCK_W-1:0] resend_clock;
        logic [1:0]         status;
        logic               last;
    } rsp_t;

    typedef struct packed {
        logic [7:0]  model;
        logic [15:0] chunk;
    } key_t;

    typedef struct packed {
        logic [CLOCK_W-1:0] clock;
        logic [7:0]         thread;
        logic               sent;
    } entry_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_KEY_RD,
        S_KEY_CHK,
        S_ADD_RD,
        S_ADD_CHK,
        S_ADD_WR,
        S_REP_RD,
        S_REP_CHK
    } state_t;

endpackage

[sv/pending_chunk_request_table.sv]
// ----------------------------------------------------------------------------
// Pending chunk request table
// Keeps queues of pending reads per (model, chunk) key, sorted by clock,
// and releases waiting threads when replies arrive.
// ----------------------------------------------------------------------------
//  channel   | handshake                 | payload
//  request   | start, accepted if !busy  | req (req_t)
//  result    | rsp_valid, one cycle      | rsp (rsp_t)
//
// The key lookup reads and checks one key slot at a time, up to KEY_SLOTS
// slots. An add then reads and compares queued entries from the tail: each
// entry with a later clock and the first one without. Then it writes the new
// entry. A reply reads and checks one entry per released thread, then checks
// the entry that stays queued, or stops when the queue empties. Each result
// appears in the cycle after the step that makes it. Reset clears all keys at
// once. Results cannot be stalled.
module pending_chunk_request_table
    import pcrt_pkg::*;
#(
    parameter int KEY_SLOTS   = 16,
    parameter int QUEUE_DEPTH = 8
) (
    input  logic clk,
    input  logic rst_n,
    input  logic start,
    output logic busy,
    input  req_t req,
    output logic rsp_valid,
    output rsp_t rsp
);

    localparam int SW  = KEY_SLOTS > 1 ? $clog2(KEY_SLOTS) : 1;
    localparam int QW  = QUEUE_DEPTH > 1 ? $clog2(QUEUE_DEPTH) : 1;
    localparam int LW  = $clog2(QUEUE_DEPTH + 1);
    localparam int PW  = LW + 1;
    localparam int ED  = KEY_SLOTS * QUEUE_DEPTH;
    localparam int EAW = ED > 1 ? $clog2(ED) : 1;

    state_t state_reg, state_next;
    req_t   req_reg, req_next;
    logic [SW-1:0] scan_reg, scan_next;
    logic [SW-1:0] free_reg, free_next;
    logic          free_found_reg, free_found_next;
    logic [SW-1:0] slot_reg, slot_next;
    logic [LW-1:0] pos_reg, pos_next;
    logic [LW-1:0] n_reg, n_next;
    rsp_t          rsp_reg, rsp_next;
    logic          rsp_valid_reg, rsp_valid_next;

    logic          in_use_reg [KEY_SLOTS];
    logic [LW-1:0] len_reg [KEY_SLOTS];
    logic [QW-1:0] head_reg [KEY_SLOTS];

    logic          slot_we;
    logic [SW-1:0] slot_sel;
    logic          in_use_wd;
    logic [LW-1:0] len_wd;
    logic [QW-1:0] head_wd;

    logic          key_we;
    key_t          key_wdata;
    key_t          key_rdata;

    logic           ent_we;
    logic [EAW-1:0] ent_waddr;
    entry_t         ent_wdata;
    logic [EAW-1:0] ent_raddr;
    entry_t         ent_rdata;

    logic          key_hit;
    logic          scan_end;
    logic          have_free;
    logic [SW-1:0] free_idx;
    logic [LW-1:0] cur_len;
    logic [QW-1:0] cur_head;
    logic [LW-1:0] found_len;
    logic [LW-1:0] pos_dec;
    logic          later;
    logic          released;

    function automatic logic [QW-1:0] phys(input logic [QW-1:0] h, input logic [LW-1:0] off);
        logic [PW-1:0] s;
        s = PW'(h) + PW'(off);
        if (s >= PW'(QUEUE_DEPTH))
        begin
            s = s - PW'(QUEUE_DEPTH);
        end
        return s[QW-1:0];
    endfunction

    function automatic logic [EAW-1:0] eaddr(input logic [SW-1:0] slot, input logic [QW-1:0] idx);
        return EAW'(slot) * EAW'(QUEUE_DEPTH) + EAW'(idx);
    endfunction

    pcrt_ram #(
        .WIDTH($bits(key_t)),
        .DEPTH(KEY_SLOTS)
    ) u_key_ram (
        .clk  (clk),
        .we   (key_we),
        .waddr(free_idx),
        .wdata(key_wdata),
        .raddr(scan_reg),
        .rdata(key_rdata)
    );

    pcrt_ram #(
        .WIDTH($bits(entry_t)),
        .DEPTH(ED)
    ) u_entry_ram (
        .clk  (clk),
        .we   (ent_we),
        .waddr(ent_waddr),
        .wdata(ent_wdata),
        .raddr(ent_raddr),
        .rdata(ent_rdata)
    );

    assign key_hit   = in_use_reg[scan_reg] && key_rdata.model == req_reg.model
                       && key_rdata.chunk == req_reg.chunk;
    assign scan_end  = scan_reg == SW'(KEY_SLOTS - 1);
    assign have_free = free_found_reg || !in_use_reg[scan_reg];
    assign free_idx  = free_found_reg ? free_reg : scan_reg;
    assign cur_len   = len_reg[slot_reg];
    assign cur_head  = head_reg[slot_reg];
    assign found_len = len_reg[scan_reg];
    assign pos_dec   = pos_reg - LW'(1);
    assign later     = ent_rdata.clock > req_reg.clock_req;
    assign released  = !later;

    assign busy      = state_reg != S_IDLE;
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    state_next = S_KEY_RD;
                end
            end
            S_KEY_RD:
            begin
                state_next = S_KEY_CHK;
            end
            S_KEY_CHK:
            begin
                if (key_hit)
                begin
                    if (req_reg.req_type == REQ_REPLY)
                    begin
                        state_next = S_REP_RD;
                    end
                    else if (found_len == LW'(QUEUE_DEPTH))
                    begin
                        state_next = S_IDLE;
                    end
                    else if (found_len == '0)
                    begin
                        state_next = S_ADD_WR;
                    end
                    else
                    begin
                        state_next = S_ADD_RD;
                    end
                end
                else if (scan_end)
                begin
                    if (req_reg.req_type == REQ_ADD && have_free)
                    begin
                        state_next = S_ADD_WR;
                    end
                    else
                    begin
                        state_next = S_IDLE;
                    end
                end
                else
                begin
                    state_next = S_KEY_RD;
                end
            end
            S_ADD_RD:
            begin
                state_next = S_ADD_CHK;
            end
            S_ADD_CHK:
            begin
                if (later && pos_dec != '0)
                begin
                    state_next = S_ADD_RD;
                end
                else
                begin
                    state_next = S_ADD_WR;
                end
            end
            S_ADD_WR:
            begin
                state_next = S_IDLE;
            end
            S_REP_RD:
            begin
                if (n_reg == cur_len)
                begin
                    state_next = S_IDLE;
                end
                else
                begin
                    state_next = S_REP_CHK;
                end
            end
            S_REP_CHK:
            begin
                if (released)
                begin
                    state_next = S_REP_RD;
                end
                else
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        req_next        = req_reg;
        scan_next       = scan_reg;
        free_next       = free_reg;
        free_found_next = free_found_reg;
        slot_next       = slot_reg;
        pos_next        = pos_reg;
        n_next          = n_reg;
        rsp_next        = '0;
        rsp_valid_next  = 1'b0;
        slot_we         = 1'b0;
        slot_sel        = slot_reg;
        in_use_wd       = 1'b1;
        len_wd          = cur_len;
        head_wd         = cur_head;
        key_we          = 1'b0;
        key_wdata.model = req_reg.model;
        key_wdata.chunk = req_reg.chunk;
        ent_we          = 1'b0;
        ent_waddr       = eaddr(slot_reg, phys(cur_head, pos_reg));
        ent_wdata       = ent_rdata;
        ent_raddr       = eaddr(slot_reg, phys(cur_head, pos_dec));
        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    req_next        = req;
                    scan_next       = '0;
                    free_found_next = 1'b0;
                end
            end
            S_KEY_CHK:
            begin
                if (!free_found_reg && !in_use_reg[scan_reg])
                begin
                    free_found_next = 1'b1;
                    free_next       = scan_reg;
                end
                if (key_hit)
                begin
                    slot_next = scan_reg;
                    pos_next  = found_len;
                    n_next    = '0;
                    if (req_reg.req_type == REQ_ADD && found_len == LW'(QUEUE_DEPTH))
                    begin
                        rsp_valid_next  = 1'b1;
                        rsp_next.status = ST_QUEUE_FULL;
                        rsp_next.last   = 1'b1;
                    end
                end
                else if (scan_end)
                begin
                    if (req_reg.req_type == REQ_ADD)
                    begin
                        if (have_free)
                        begin
                            slot_next = free_idx;
                            pos_next  = '0;
                            key_we    = 1'b1;
                            slot_we   = 1'b1;
                            slot_sel  = free_idx;
                            in_use_wd = 1'b1;
                            len_wd    = '0;
                            head_wd   = '0;
                        end
                        else
                        begin
                            rsp_valid_next  = 1'b1;
                            rsp_next.status = ST_KEYS_FULL;
                            rsp_next.last   = 1'b1;
                        end
                    end
                    else
                    begin
                        rsp_valid_next = 1'b1;
                        rsp_next.last  = 1'b1;
                    end
                end
                else
                begin
                    scan_next = scan_reg + SW'(1);
                end
            end
            S_ADD_CHK:
            begin
                if (later)
                begin
                    ent_we    = 1'b1;
                    ent_waddr = eaddr(slot_reg, phys(cur_head, pos_reg));
                    ent_wdata = ent_rdata;
                    pos_next  = pos_dec;
                end
            end
            S_ADD_WR:
            begin
                ent_we           = 1'b1;
                ent_waddr        = eaddr(slot_reg, phys(cur_head, pos_reg));
                ent_wdata.clock  = req_reg.clock_req;
                ent_wdata.thread = req_reg.thread;
                ent_wdata.sent   = pos_reg == '0;
                slot_we          = 1'b1;
                in_use_wd        = 1'b1;
                len_wd           = cur_len + LW'(1);
                rsp_valid_next   = 1'b1;
                rsp_next.send_needed = pos_reg == '0;
                rsp_next.status  = ST_OK;
                rsp_next.last    = 1'b1;
            end
            S_REP_RD:
            begin
                ent_raddr = eaddr(slot_reg, phys(cur_head, n_reg));
                if (n_reg == cur_len)
                begin
                    slot_we        = 1'b1;
                    in_use_wd      = 1'b0;
                    len_wd         = '0;
                    rsp_valid_next = 1'b1;
                    rsp_next.last  = 1'b1;
                end
            end
            S_REP_CHK:
            begin
                rsp_valid_next = 1'b1;
                if (released)
                begin
                    rsp_next.thread_valid    = 1'b1;
                    rsp_next.released_thread = ent_rdata.thread;
                    n_next                   = n_reg + LW'(1);
                end
                else
                begin
                    slot_we       = 1'b1;
                    in_use_wd     = 1'b1;
                    len_wd        = cur_len - n_reg;
                    head_wd       = phys(cur_head, n_reg);
                    rsp_next.last = 1'b1;
                    if (!ent_rdata.sent)
                    begin
                        rsp_next.resend_valid = 1'b1;
                        rsp_next.resend_clock = ent_rdata.clock;
                        ent_we                = 1'b1;
                        ent_waddr             = eaddr(slot_reg, phys(cur_head, n_reg));
                        ent_wdata.sent        = 1'b1;
                    end
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            rsp_valid_reg  <= 1'b0;
            free_found_reg <= 1'b0;
            for (int i = 0; i < KEY_SLOTS; i++)
            begin
                in_use_reg[i] <= 1'b0;
                len_reg[i]    <= '0;
                head_reg[i]   <= '0;
            end
        end
        else
        begin
            state_reg      <= state_next;
            rsp_valid_reg  <= rsp_valid_next;
            free_found_reg <= free_found_next;
            if (slot_we)
            begin
                in_use_reg[slot_sel] <= in_use_wd;
                len_reg[slot_sel]    <= len_wd;
                head_reg[slot_sel]   <= head_wd;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        req_reg  <= req_next;
        scan_reg <= scan_next;
        free_reg <= free_next;
        slot_reg <= slot_next;
        pos_reg  <= pos_next;
        n_reg    <= n_next;
        rsp_reg  <= rsp_next;
    end

endmodule

[sv/pcrt_ram.sv]
// ----------------------------------------------------------------------------
// Pending chunk request table: generic RAM
// One write port and one read port with the read data registered.
// ----------------------------------------------------------------------------
module pcrt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                  clk,
    input  logic                                  we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                      wdata,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                      rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata <= mem_reg[raddr];
    end

endmodule

[test/tb_top.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Pending chunk request table testbench
// Drives adds and replies over a small pool of keys, predicts the send, release
// and resend results from a behavioural copy of the table, and checks every
// result item field by field against the oldest expected one.
// ----------------------------------------------------------------------------
class pcrt_scoreboard;

    localparam int SLOTS = 16;
    localparam int DEPTH = 8;

    bit                           in_use [SLOTS];
    logic [7:0]                   slot_model [SLOTS];
    logic [15:0]                  slot_chunk [SLOTS];
    int                           depth_used [SLOTS];
    logic [pcrt_pkg::CLOCK_W-1:0] waiter_clock [SLOTS][DEPTH];
    logic [7:0]                   waiter_thread [SLOTS][DEPTH];
    bit                           waiter_sent [SLOTS][DEPTH];
    pcrt_pkg::rsp_t               awaited [$];
    int                           errors;

    function int lookup(logic [7:0] m, logic [15:0] c);
        for (int s = 0; s < SLOTS; s++)
        begin
            if (in_use[s] && slot_model[s] == m && slot_chunk[s] == c)
            begin
                return s;
            end
        end
        return -1;
    endfunction

    function void push(bit sn, bit tv, logic [7:0] th, bit rv,
                       logic [pcrt_pkg::CLOCK_W-1:0] rc, pcrt_pkg::status_t st, bit lst);
        pcrt_pkg::rsp_t r;
        r.send_needed     = sn;
        r.thread_valid    = tv;
        r.released_thread = th;
        r.resend_valid    = rv;
        r.resend_clock    = rc;
        r.status          = st;
        r.last            = lst;
        awaited.insert(awaited.size(), r);
    endfunction

    function void note_request(pcrt_pkg::req_t q);
        int s;
        int pos;
        int n;
        int len;
        bit rv;
        logic [pcrt_pkg::CLOCK_W-1:0] rc;
        s = lookup(q.model, q.chunk);
        if (q.req_type == pcrt_pkg::REQ_ADD)
        begin
            if (s < 0)
            begin
                for (int f = 0; f < SLOTS; f++)
                begin
                    if (!in_use[f])
                    begin
                        s = f;
                        break;
                    end
                end
                if (s < 0)
                begin
                    push(1'b0, 1'b0, 8'h00, 1'b0, '0, pcrt_pkg::ST_KEYS_FULL, 1'b1);
                    return;
                end
                in_use[s] = 1'b1;
                slot_model[s] = q.model;
                slot_chunk[s] = q.chunk;
                depth_used[s] = 0;
            end
            len = depth_used[s];
            if (len >= DEPTH)
            begin
                push(1'b0, 1'b0, 8'h00, 1'b0, '0, pcrt_pkg::ST_QUEUE_FULL, 1'b1);
                return;
            end
            pos = len;
            while (pos > 0 && waiter_clock[s][pos-1] > q.clock_req)
            begin
                pos--;
            end
            for (int i = len; i > pos; i--)
            begin
                waiter_clock[s][i] = waiter_clock[s][i-1];
                waiter_thread[s][i] = waiter_thread[s][i-1];
                waiter_sent[s][i] = waiter_sent[s][i-1];
            end
            waiter_clock[s][pos] = q.clock_req;
            waiter_thread[s][pos] = q.thread;
            waiter_sent[s][pos] = (pos == 0);
            depth_used[s] = len + 1;
            push(pos == 0, 1'b0, 8'h00, 1'b0, '0, pcrt_pkg::ST_OK, 1'b1);
        end
        else
        begin
            rv = 1'b0;
            rc = '0;
            if (s >= 0)
            begin
                len = depth_used[s];
                n = 0;
                while (n < len && waiter_clock[s][n] <= q.clock_req)
                begin
                    push(1'b0, 1'b1, waiter_thread[s][n], 1'b0, '0, pcrt_pkg::ST_OK, 1'b0);
                    n++;
                end
                for (int i = n; i < len; i++)
                begin
                    waiter_clock[s][i-n] = waiter_clock[s][i];
                    waiter_thread[s][i-n] = waiter_thread[s][i];
                    waiter_sent[s][i-n] = waiter_sent[s][i];
                end
                len -= n;
                depth_used[s] = len;
                if (len == 0)
                begin
                    in_use[s] = 1'b0;
                end
                else if (!waiter_sent[s][0])
                begin
                    rv = 1'b1;
                    rc = waiter_clock[s][0];
                    waiter_sent[s][0] = 1'b1;
                end
            end
            push(1'b0, 1'b0, 8'h00, rv, rc, pcrt_pkg::ST_OK, 1'b1);
        end
    endfunction

    function void check_result(pcrt_pkg::rsp_t got);
        pcrt_pkg::rsp_t want;
        if (awaited.size() == 0)
        begin
            $error("Result item arrived with none expected: %p", got);
            errors++;
            return;
        end
        want = awaited[0];
        awaited.delete(0);
        if (got.send_needed !== want.send_needed)
        begin
            $error("send_needed: expected %0d, got %0d", want.send_needed, got.send_needed);
            errors++;
        end
        if (got.thread_valid !== want.thread_valid)
        begin
            $error("thread_valid: expected %0d, got %0d", want.thread_valid, got.thread_valid);
            errors++;
        end
        if (got.released_thread !== want.released_thread)
        begin
            $error("released_thread: expected %0d, got %0d",
                   want.released_thread, got.released_thread);
            errors++;
        end
        if (got.resend_valid !== want.resend_valid)
        begin
            $error("resend_valid: expected %0d, got %0d", want.resend_valid, got.resend_valid);
            errors++;
        end
        if (got.resend_clock !== want.resend_clock)
        begin
            $error("resend_clock: expected %0d, got %0d", want.resend_clock, got.resend_clock);
            errors++;
        end
        if (got.status !== want.status)
        begin
            $error("status: expected %0d, got %0d", want.status, got.status);
            errors++;
        end
        if (got.last !== want.last)
        begin
            $error("last: expected %0d, got %0d", want.last, got.last);
            errors++;
        end
    endfunction

endclass

module tb_top
    import pcrt_pkg::*;
();

    localparam int STALL_LIMIT = 2000;

    logic clk;
    logic rst_n;
    logic start;
    logic busy;
    req_t req;
    logic rsp_valid;
    rsp_t rsp;

    pcrt_scoreboard table_model;
    int             idle_cycles;

    pending_chunk_request_table u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp       (rsp)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    always @(posedge clk)
    begin
        if (rst_n && rsp_valid)
        begin
            table_model.check_result(rsp);
        end
    end

    always @(posedge clk)
    begin
        if ((start && !busy) || rsp_valid)
        begin
            idle_cycles <= 0;
        end
        else
        begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= STALL_LIMIT)
        begin
            $display("TEST FAILED");
            $finish;
        end
    end

    task automatic issue(req_kind_t kind, logic [7:0] m, logic [15:0] c,
                         logic [CLOCK_W-1:0] ck, logic [7:0] th, bit gaps);
        int gap;
        req_t q;
        gap = gaps ? $urandom_range(0, 13) : 0;
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        q.req_type  = kind;
        q.model     = m;
        q.chunk     = c;
        q.clock_req = ck;
        q.thread    = th;
        start <= 1'b1;
        req   <= q;
        @(posedge clk);
        while (busy)
        begin
            @(posedge clk);
        end
        table_model.note_request(q);
    endtask

    task automatic drain();
        start <= 1'b0;
        @(posedge clk);
        while (table_model.awaited.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (60) @(posedge clk);
    endtask

    initial
    begin
        logic [7:0]  km [6];
        logic [15:0] kc [6];
        int          k;
        int          p;
        table_model = new();
        idle_cycles = 0;
        rst_n = 1'b0;
        start = 1'b0;
        req   = '0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        issue(REQ_REPLY, 8'hFF, 16'hFFFF, 31'h7FFFFFFF, 8'hFF, 1'b0);
        issue(REQ_ADD, 8'h00, 16'h0000, 31'd50, 8'h00, 1'b0);
        issue(REQ_ADD, 8'h00, 16'h0000, 31'd10, 8'hFF, 1'b0);
        issue(REQ_ADD, 8'h00, 16'h0000, 31'd50, 8'h11, 1'b0);
        issue(REQ_ADD, 8'h00, 16'h0000, 31'h7FFFFFFF, 8'h22, 1'b0);
        issue(REQ_ADD, 8'h00, 16'h0000, 31'd0, 8'h33, 1'b0);
        issue(REQ_ADD, 8'h00, 16'h0000, 31'd30, 8'h44, 1'b0);
        issue(REQ_ADD, 8'h00, 16'h0000, 31'd30, 8'h55, 1'b0);
        issue(REQ_ADD, 8'h00, 16'h0000, 31'd70, 8'h66, 1'b0);
        issue(REQ_ADD, 8'h00, 16'h0000, 31'd5, 8'h77, 1'b0);
        issue(REQ_REPLY, 8'h00, 16'h0000, 31'd0, 8'h00, 1'b0);
        issue(REQ_REPLY, 8'h00, 16'h0000, 31'd50, 8'h00, 1'b0);
        for (int i = 0; i < 16; i++)
        begin
            issue(REQ_ADD, 8'(8'hA0 + i), 16'(16'hFFFF - i), 31'd100, 8'(i), 1'b0);
        end
        issue(REQ_ADD, 8'hFF, 16'hFFFF, 31'd1, 8'h01, 1'b0);
        drain();
        issue(REQ_REPLY, 8'h00, 16'h0000, 31'h7FFFFFFF, 8'h00, 1'b0);
        for (int i = 0; i < 16; i++)
        begin
            issue(REQ_REPLY, 8'(8'hA0 + i), 16'(16'hFFFF - i), 31'd100, 8'h00, 1'b1);
        end
        drain();

        for (int i = 0; i < 6; i++)
        begin
            km[i] = 8'($urandom);
            kc[i] = 16'($urandom);
        end
        for (int n = 0; n < 335; n++)
        begin
            k = $urandom_range(0, 5);
            p = $urandom_range(0, 99);
            if (n == 190)
            begin
                drain();
            end
            if (p < 55)
            begin
                issue(REQ_ADD, km[k], kc[k], 31'($urandom_range(0, 40) + n / 4),
                      8'($urandom), n % 40 >= 20);
            end
            else if (p < 90)
            begin
                issue(REQ_REPLY, km[k], kc[k], 31'($urandom_range(0, 40) + n / 4),
                      8'($urandom), n % 40 >= 20);
            end
            else if (p < 95)
            begin
                issue(REQ_ADD, 8'($urandom), 16'($urandom), 31'($urandom), 8'($urandom),
                      n % 40 >= 20);
            end
            else
            begin
                issue(REQ_REPLY, 8'($urandom), 16'($urandom), 31'($urandom), 8'($urandom),
                      n % 40 >= 20);
            end
        end
        drain();
        if (table_model.errors == 0)
        begin
            $display("TEST PASSED");
        end
        else
        begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule

[files.f]
sv/pcrt_pkg.sv
sv/pcrt_ram.sv
sv/pending_chunk_request_table.sv
test/tb_top.sv
